[sv/sdm_pkg.sv]
// Shared constants, types and helpers of the stream suffix dictionary matcher.
package sdm_pkg;

   // Dictionary and stream limits
   localparam int NODE_COUNT   = 4096;
   localparam int MAX_WORD_LEN = 64;
   localparam int ALPHABET     = 26;

   // Field widths fixed by the interface
   localparam int LETTER_W = 5;
   localparam int STATUS_W = 2;

   // Derived widths
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int CNT_W       = $clog2(NODE_COUNT + 1);
   localparam int TABLE_DEPTH = NODE_COUNT * ALPHABET;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int LEN_IDX_W   = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int LEN_W       = $clog2(MAX_WORD_LEN + 2);
   localparam int FILL_W      = $clog2(MAX_WORD_LEN + 1);

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

   // One trie edge: child node plus the word-end flag of that child
   typedef struct packed {
      logic              mark;
      logic [NODE_W-1:0] child;
   } entry_type;

   // Command to the node table
   typedef struct packed {
      logic                rd;
      logic                wr;
      logic [NODE_W-1:0]   node;
      logic [LETTER_W-1:0] letter;
      entry_type           wdata;
   } tbl_cmd_type;

   // Step a ring or buffer index back by one, wrapping at the depth
   function automatic logic [LEN_IDX_W-1:0] idx_dec(input logic [LEN_IDX_W-1:0] pos);
      logic [LEN_IDX_W-1:0] res;
      if (pos == '0) begin
         res = LEN_IDX_W'(MAX_WORD_LEN - 1);
      end else begin
         res = pos - 1'b1;
      end
      return res;
   endfunction

   // Step a ring index forward by one, wrapping at the depth
   function automatic logic [LEN_IDX_W-1:0] idx_inc(input logic [LEN_IDX_W-1:0] pos);
      logic [LEN_IDX_W-1:0] res;
      if (pos == LEN_IDX_W'(MAX_WORD_LEN - 1)) begin
         res = '0;
      end else begin
         res = pos + 1'b1;
      end
      return res;
   endfunction

endpackage

[sv/sdm_req_if.sv]
// Request channel: one letter word with its kind and end-of-word mark.
interface sdm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [sdm_pkg::LETTER_W-1:0] letter;
   logic                        last_of_word;

   modport source (output valid, output req_type, output letter, output last_of_word,
                   input ready);
   modport sink (input valid, input req_type, input letter, input last_of_word,
                 output ready);
endinterface

[sv/sdm_rsp_if.sv]
// Response channel: match flag and insert status.
interface sdm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         matched;
   logic [sdm_pkg::STATUS_W-1:0] status;

   modport source (output valid, output matched, output status, input ready);
   modport sink (input valid, input matched, input status, output ready);
endinterface

[sv/sdm_node_table.sv]
// Trie node table: edge memory, slot address unit and clearing sweep after reset.
module sdm_node_table (
   input  logic                 clock,
   input  logic                 reset,
   input  sdm_pkg::tbl_cmd_type cmd,
   output sdm_pkg::entry_type   rdata,
   output logic                 busy
);
   import sdm_pkg::*;

   entry_type               mem [TABLE_DEPTH];
   entry_type               rdata_ff;
   logic                    busy_ff, busy_in;
   logic [TABLE_AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [TABLE_AW-1:0]     slot;
   logic [TABLE_AW-1:0]     wr_addr;
   entry_type               wr_data;
   logic                    wr_en;

   // Form the slot of an edge from its parent node and letter
   assign slot = TABLE_AW'(TABLE_AW'(cmd.node) * TABLE_AW'(ALPHABET))
                 + TABLE_AW'(cmd.letter);

   // Advance the clearing sweep, one entry a cycle
   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == TABLE_AW'(TABLE_DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Select the sweep or the sequencer for the write port
   always_comb begin
      if (busy_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.wr;
         wr_addr = slot;
         wr_data = cmd.wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read data
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff <= mem[slot];
      end
   end

   assign rdata = rdata_ff;
   assign busy  = busy_ff;

endmodule

[sv/stream_suffix_dictionary_matcher_core.sv]
// Top level of the stream suffix dictionary matcher: sequencer, letter stores, response register.
//
// Load words collect dictionary letters; the word marked last is inserted into a reversed trie,
// last letter first. Query words append a letter to a 64-letter history and walk the trie from
// the newest letter backward; matched reports that some suffix of the stream is a whole word.
// Every request word gets exactly one response word. Status is nonzero only on a word end:
// 1 when the node table fills (nodes made so far stay, the word is not marked), 2 when the word
// is longer than 64 letters. A word holding a letter above z is dropped with status 0.
// The node table is one single-port memory with a shared node*26+letter address unit, and
// each trie step is a read followed by a check. A load that inserts nothing (not a word end,
// an overlong word or a word with a letter above z) goes straight to the finish step; a word
// end that inserts takes one trie step per letter inserted, and a query one trie step per
// history letter walked, the walk stopping on a letter above z without a read. The block
// takes one request at a time and accepts the next one while the previous response still waits
// on the response register; a further result waits until that register is taken.
// After reset the node table is cleared one entry a cycle, and no request is accepted until
// that pass ends.
module stream_suffix_dictionary_matcher_core (
   input logic      clock,
   input logic      reset,
   sdm_req_if.sink  req,
   sdm_rsp_if.source rsp
);
   import sdm_pkg::*;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_IDLE     = 4'd1;
   localparam logic [3:0] ST_INS_PREP = 4'd2;
   localparam logic [3:0] ST_INS_TBL  = 4'd3;
   localparam logic [3:0] ST_INS_CHK  = 4'd4;
   localparam logic [3:0] ST_QRY_PREP = 4'd5;
   localparam logic [3:0] ST_QRY_TBL  = 4'd6;
   localparam logic [3:0] ST_QRY_CHK  = 4'd7;
   localparam logic [3:0] ST_FINISH   = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [LEN_W-1:0]     word_len_ff, word_len_in;
   logic                 word_bad_ff, word_bad_in;
   logic [LEN_IDX_W-1:0] hist_head_ff, hist_head_in;
   logic [FILL_W-1:0]    hist_fill_ff, hist_fill_in;
   logic [CNT_W-1:0]     nodes_used_ff, nodes_used_in;
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [LEN_IDX_W-1:0] pos_ff, pos_in;
   logic [FILL_W-1:0]    left_ff, left_in;
   logic [LETTER_W-1:0]  step_letter_ff, step_letter_in;
   logic                 res_matched_ff, res_matched_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_matched_ff, rsp_matched_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   logic [LETTER_W-1:0]  ring_mem [MAX_WORD_LEN];
   logic [LETTER_W-1:0]  buf_mem [MAX_WORD_LEN];
   logic [LETTER_W-1:0]  ring_rd_ff;
   logic [LETTER_W-1:0]  buf_rd_ff;
   logic                 ring_we, ring_re, buf_we, buf_re;

   tbl_cmd_type          tbl_cmd;
   entry_type            tbl_rdata;
   logic                 tbl_busy;

   logic                 accept;
   logic                 len_room;
   logic [LEN_W-1:0]     len_next;
   logic                 bad_next;
   logic                 step_last;
   logic                 out_free;

   sdm_node_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .rdata (tbl_rdata),
      .busy  (tbl_busy)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign len_room  = (word_len_ff < LEN_W'(MAX_WORD_LEN));
   assign len_next  = len_room ? (word_len_ff + 1'b1) : LEN_W'(MAX_WORD_LEN + 1);
   assign bad_next  = word_bad_ff || (len_room && (req.letter >= LETTER_W'(ALPHABET)));
   assign step_last = (left_ff == FILL_W'(1));
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // Sequence load, insert and walk steps
   always_comb begin
      state_in       = state_ff;
      word_len_in    = word_len_ff;
      word_bad_in    = word_bad_ff;
      hist_head_in   = hist_head_ff;
      hist_fill_in   = hist_fill_ff;
      nodes_used_in  = nodes_used_ff;
      node_in        = node_ff;
      pos_in         = pos_ff;
      left_in        = left_ff;
      step_letter_in = step_letter_ff;
      res_matched_in = res_matched_ff;
      res_status_in  = res_status_ff;
      ring_we        = 1'b0;
      ring_re        = 1'b0;
      buf_we         = 1'b0;
      buf_re         = 1'b0;
      tbl_cmd        = '0;
      tbl_cmd.node   = node_ff;
      tbl_cmd.letter = step_letter_ff;

      case (state_ff)
         ST_CLEAR: begin
            if (!tbl_busy) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               node_in        = '0;
               res_matched_in = 1'b0;
               res_status_in  = STATUS_OK;
               if (req.req_type == REQ_LOAD) begin
                  buf_we = len_room;
                  if (!req.last_of_word) begin
                     word_len_in = len_next;
                     word_bad_in = bad_next;
                     state_in    = ST_FINISH;
                  end else begin
                     word_len_in = '0;
                     word_bad_in = 1'b0;
                     if (len_next > LEN_W'(MAX_WORD_LEN)) begin
                        res_status_in = STATUS_TOO_LONG;
                        state_in      = ST_FINISH;
                     end else if (bad_next) begin
                        state_in = ST_FINISH;
                     end else begin
                        left_in  = FILL_W'(len_next);
                        pos_in   = word_len_ff[LEN_IDX_W-1:0];
                        state_in = ST_INS_PREP;
                     end
                  end
               end else begin
                  ring_we      = 1'b1;
                  hist_head_in = idx_inc(hist_head_ff);
                  if (hist_fill_ff < FILL_W'(MAX_WORD_LEN)) begin
                     hist_fill_in = hist_fill_ff + 1'b1;
                     left_in      = hist_fill_ff + 1'b1;
                  end else begin
                     left_in = hist_fill_ff;
                  end
                  pos_in   = hist_head_ff;
                  state_in = ST_QRY_PREP;
               end
            end
         end

         // Fetch the last buffered letter
         ST_INS_PREP: begin
            buf_re   = 1'b1;
            pos_in   = idx_dec(pos_ff);
            state_in = ST_INS_TBL;
         end

         // Read the edge and prefetch the next letter
         ST_INS_TBL: begin
            tbl_cmd.rd     = 1'b1;
            tbl_cmd.letter = buf_rd_ff;
            step_letter_in = buf_rd_ff;
            buf_re         = 1'b1;
            pos_in         = idx_dec(pos_ff);
            state_in       = ST_INS_CHK;
         end

         // Follow or create the edge; mark it on the final letter
         ST_INS_CHK: begin
            left_in = left_ff - 1'b1;
            if (tbl_rdata.child == '0) begin
               if (nodes_used_ff >= CNT_W'(NODE_COUNT)) begin
                  res_status_in = STATUS_FULL;
                  state_in      = ST_FINISH;
               end else begin
                  tbl_cmd.wr          = 1'b1;
                  tbl_cmd.wdata.mark  = step_last;
                  tbl_cmd.wdata.child = nodes_used_ff[NODE_W-1:0];
                  node_in             = nodes_used_ff[NODE_W-1:0];
                  nodes_used_in       = nodes_used_ff + 1'b1;
                  state_in            = step_last ? ST_FINISH : ST_INS_TBL;
               end
            end else begin
               if (step_last) begin
                  tbl_cmd.wr          = 1'b1;
                  tbl_cmd.wdata.mark  = 1'b1;
                  tbl_cmd.wdata.child = tbl_rdata.child;
               end
               node_in  = tbl_rdata.child;
               state_in = step_last ? ST_FINISH : ST_INS_TBL;
            end
         end

         // Fetch the newest history letter
         ST_QRY_PREP: begin
            ring_re  = 1'b1;
            pos_in   = idx_dec(pos_ff);
            state_in = ST_QRY_TBL;
         end

         // Drop the walk on a letter above z, else read the edge
         ST_QRY_TBL: begin
            if (ring_rd_ff >= LETTER_W'(ALPHABET)) begin
               state_in = ST_FINISH;
            end else begin
               tbl_cmd.rd     = 1'b1;
               tbl_cmd.letter = ring_rd_ff;
               ring_re        = 1'b1;
               pos_in         = idx_dec(pos_ff);
               state_in       = ST_QRY_CHK;
            end
         end

         // Stop on a missing edge, a word end or the oldest history letter, else step back
         ST_QRY_CHK: begin
            if (tbl_rdata.child == '0) begin
               state_in = ST_FINISH;
            end else if (tbl_rdata.mark) begin
               res_matched_in = 1'b1;
               state_in       = ST_FINISH;
            end else begin
               node_in  = tbl_rdata.child;
               left_in  = left_ff - 1'b1;
               state_in = step_last ? ST_FINISH : ST_QRY_TBL;
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Load the response register when the result is ready and the slot frees up
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_status_in  = rsp_status_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_matched_in = res_matched_ff;
         rsp_status_in  = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         word_len_ff   <= '0;
         word_bad_ff   <= 1'b0;
         hist_head_ff  <= '0;
         hist_fill_ff  <= '0;
         nodes_used_ff <= CNT_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_len_ff   <= word_len_in;
         word_bad_ff   <= word_bad_in;
         hist_head_ff  <= hist_head_in;
         hist_fill_ff  <= hist_fill_in;
         nodes_used_ff <= nodes_used_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold walk and result payload
   always_ff @(posedge clock) begin
      node_ff        <= node_in;
      pos_ff         <= pos_in;
      left_ff        <= left_in;
      step_letter_ff <= step_letter_in;
      res_matched_ff <= res_matched_in;
      res_status_ff  <= res_status_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // History ring
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[hist_head_ff] <= req.letter;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_re) begin
         ring_rd_ff <= ring_mem[pos_ff];
      end
   end

   // Word buffer
   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_mem[word_len_ff[LEN_IDX_W-1:0]] <= req.letter;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_re) begin
         buf_rd_ff <= buf_mem[pos_ff];
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.matched = rsp_matched_ff;
   assign rsp.status  = rsp_status_ff;

`ifndef SYNTHESIS
   a_nodes_range: assert property (@(posedge clock) disable iff (reset)
      (nodes_used_ff >= CNT_W'(1)) && (nodes_used_ff <= CNT_W'(NODE_COUNT)))
      else $error("node count out of range");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !tbl_busy)
      else $error("request accepted during table clear");

   a_write_only_on_insert: assert property (@(posedge clock) disable iff (reset)
      tbl_cmd.wr |-> (state_ff == ST_INS_CHK))
      else $error("table write outside insert step");

   a_match_has_ok_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_matched_ff) |-> (rsp_status_ff == STATUS_OK))
      else $error("match reported with nonzero status");
`endif

endmodule

[tb/tb_stream_suffix_dictionary_matcher_core.sv]
// Self-checking testbench for the stream suffix dictionary matcher core.
`timescale 1ns / 1ps

module tb_stream_suffix_dictionary_matcher_core;
   import sdm_pkg::*;

   localparam int          HALF_PERIOD   = 4;
   localparam int          RESET_CYCLES  = 12;
   localparam int          RANDOM_ITEMS  = 1550;
   localparam int          HOLDOFF_LEN   = 500;
   localparam int          DRAIN_CYCLES  = 400;
   localparam int          MAX_REPORTS   = 100;
   localparam int unsigned LETTER_MAX    = (1 << LETTER_W) - 1;
   // Clearing pass plus ~1950 words at worst-case walk, stall and gap, taken several times
   localparam longint      TIMEOUT_NS    = 64'd50_000_000;

   typedef logic [LETTER_W-1:0] letter_q_type[$];

   typedef struct packed {
      logic                matched;
      logic [STATUS_W-1:0] status;
   } match_outcome_type;

   typedef enum int { RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_SPARSE } rdy_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sdm_req_if req_if ();
   sdm_rsp_if rsp_if ();

   stream_suffix_dictionary_matcher_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // Shadow of the dictionary trie, history ring and word buffer
   int unsigned         trie_child [TABLE_DEPTH];
   bit                  word_end   [NODE_COUNT];
   int unsigned         node_total = 1;
   bit [LETTER_W-1:0]   hist_ring  [MAX_WORD_LEN];
   int unsigned         hist_head  = 0;
   int unsigned         hist_fill  = 0;
   bit [LETTER_W-1:0]   word_buf   [MAX_WORD_LEN];
   int unsigned         word_len   = 0;

   match_outcome_type   pending_outcomes[$];
   int unsigned         letters_sent  = 0;
   int unsigned         rsp_count     = 0;
   int unsigned         error_count   = 0;
   int unsigned         burst_left    = 0;

   // Receiver stall control
   bit                  holdoff_pending = 1'b0;
   int unsigned         holdoff_left    = 0;
   rdy_mode_type        rdy_mode        = RDY_ALWAYS;
   int unsigned         rdy_mode_left   = 0;
   int unsigned         rdy_phase       = 0;

   // Insert the buffered word last letter first; return the insert status
   function automatic logic [STATUS_W-1:0] insert_buffered_word();
      int unsigned node;
      int unsigned slot;
      int unsigned i;
      if (word_len > MAX_WORD_LEN) begin
         return STATUS_TOO_LONG;
      end
      for (i = 0; i < word_len; i++) begin
         if (word_buf[i] >= ALPHABET) begin
            return STATUS_OK;
         end
      end
      node = 0;
      for (i = word_len; i > 0; i--) begin
         slot = node * ALPHABET + word_buf[i-1];
         if (trie_child[slot] == 0) begin
            if (node_total >= NODE_COUNT) begin
               return STATUS_FULL;
            end
            trie_child[slot] = node_total;
            node_total++;
         end
         node = trie_child[slot];
      end
      word_end[node] = 1'b1;
      return STATUS_OK;
   endfunction

   // Walk the trie from the newest history letter backward
   function automatic logic suffix_is_word();
      int unsigned node;
      int unsigned pos;
      int unsigned k;
      int unsigned c;
      node = 0;
      pos  = hist_head;
      for (k = 0; k < hist_fill; k++) begin
         pos = (pos == 0) ? MAX_WORD_LEN - 1 : pos - 1;
         c   = hist_ring[pos];
         if (c >= ALPHABET) begin
            return 1'b0;
         end
         node = trie_child[node * ALPHABET + c];
         if (node == 0) begin
            return 1'b0;
         end
         if (word_end[node]) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Advance the shadow state by one accepted word and return its response
   function automatic match_outcome_type predict_outcome(input logic kind,
                                                         input logic [LETTER_W-1:0] letter,
                                                         input logic last);
      match_outcome_type res;
      res = '0;
      if (kind == REQ_LOAD) begin
         if (word_len < MAX_WORD_LEN) begin
            word_buf[word_len] = letter;
            word_len++;
         end else begin
            word_len = MAX_WORD_LEN + 1;
         end
         if (last) begin
            res.status = insert_buffered_word();
            word_len   = 0;
         end
      end else begin
         hist_ring[hist_head] = letter;
         hist_head = (hist_head + 1 >= MAX_WORD_LEN) ? 0 : hist_head + 1;
         if (hist_fill < MAX_WORD_LEN) begin
            hist_fill++;
         end
         res.matched = suffix_is_word();
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("[%0t] mismatch on response %0d: %s", $time, rsp_count, what);
      end
   endtask

   // Offer one word in bursts with random gaps; record its expected response on accept
   task automatic send_letter(input logic kind, input logic [LETTER_W-1:0] letter,
                              input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 16);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 150)
                                                  : $urandom_range(1, 12);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.req_type     <= kind;
      req_if.letter       <= letter;
      req_if.last_of_word <= last;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
      letters_sent++;
      pending_outcomes.push_back(predict_outcome(kind, letter, last));
   endtask

   // Drop valid and hold until every expected response has come back
   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   task automatic load_word(input letter_q_type letters);
      int unsigned i;
      for (i = 0; i < letters.size(); i++) begin
         send_letter(REQ_LOAD, letters[i], i == letters.size() - 1);
      end
   endtask

   task automatic query_stream(input letter_q_type letters);
      int unsigned i;
      for (i = 0; i < letters.size(); i++) begin
         send_letter(REQ_QUERY, letters[i], 1'($urandom_range(0, 1)));
      end
   endtask

   function automatic letter_q_type random_word(input int unsigned len, input int unsigned lo,
                                                input int unsigned hi);
      letter_q_type res;
      int unsigned i;
      res = {};
      for (i = 0; i < len; i++) begin
         res.push_back(LETTER_W'($urandom_range(lo, hi)));
      end
      return res;
   endfunction

   // Mostly letters of a narrow span so that words and queries meet, with some spill
   function automatic logic [LETTER_W-1:0] pick_letter(input int unsigned span);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         return LETTER_W'($urandom_range(ALPHABET, LETTER_MAX));
      end
      if (roll < 10) begin
         return LETTER_W'($urandom_range(0, ALPHABET - 1));
      end
      return LETTER_W'($urandom_range(0, span - 1));
   endfunction

   // Hand-picked words and queries covering the edge cases
   task automatic test_directed_words();
      // single letter at the top of the alphabet, then a two-letter word
      send_letter(REQ_LOAD, LETTER_W'(25), 1'b1);
      send_letter(REQ_LOAD, LETTER_W'(0), 1'b0);
      send_letter(REQ_LOAD, LETTER_W'(1), 1'b1);
      send_letter(REQ_QUERY, LETTER_W'(0), 1'b0);
      // end mark set on a query is ignored
      send_letter(REQ_QUERY, LETTER_W'(1), 1'b1);
      send_letter(REQ_QUERY, LETTER_W'(25), 1'b0);
      // letters above z enter the history and block the walk
      send_letter(REQ_QUERY, LETTER_W'(LETTER_MAX), 1'b0);
      send_letter(REQ_QUERY, LETTER_W'(1), 1'b0);
      send_letter(REQ_QUERY, LETTER_W'(ALPHABET), 1'b0);
      // a word holding a letter above z is dropped with status ok
      send_letter(REQ_LOAD, LETTER_W'(2), 1'b0);
      send_letter(REQ_LOAD, LETTER_W'(ALPHABET), 1'b0);
      send_letter(REQ_LOAD, LETTER_W'(3), 1'b1);
      send_letter(REQ_QUERY, LETTER_W'(3), 1'b0);
      // a query in the middle of a word leaves the buffer alone
      send_letter(REQ_LOAD, LETTER_W'(3), 1'b0);
      send_letter(REQ_QUERY, LETTER_W'(3), 1'b1);
      send_letter(REQ_LOAD, LETTER_W'(4), 1'b1);
      send_letter(REQ_QUERY, LETTER_W'(4), 1'b0);
      // letter with the top field bit set
      send_letter(REQ_LOAD, LETTER_W'(16), 1'b1);
      send_letter(REQ_QUERY, LETTER_W'(16), 1'b0);
      // single out-of-range letter as a whole word
      send_letter(REQ_LOAD, LETTER_W'(LETTER_MAX), 1'b1);
      // a word whose node already exists only gets marked
      send_letter(REQ_LOAD, LETTER_W'(1), 1'b1);
      send_letter(REQ_QUERY, LETTER_W'(1), 1'b0);
      pause_until_drained();
   endtask

   // Longest allowed word with a full-depth walk, then words past the limit
   task automatic test_word_length_limits();
      letter_q_type word;
      // f..p keep clear of the short words already loaded
      word = random_word(MAX_WORD_LEN, 5, 15);
      load_word(word);
      query_stream(word);
      load_word(random_word(MAX_WORD_LEN + 1, 0, ALPHABET - 1));
      load_word(random_word(MAX_WORD_LEN + 6, 0, ALPHABET - 1));
      // the length count must restart after an overlong word
      load_word(random_word(3, 5, 15));
      query_stream(random_word(70, 5, 15));
      pause_until_drained();
   endtask

   // Stall responses for a long stretch while words keep coming
   task automatic test_response_holdoff();
      int unsigned i;
      holdoff_pending = 1'b1;
      for (i = 0; i < 40; i++) begin
         send_letter(($urandom_range(0, 2) == 0) ? REQ_LOAD : REQ_QUERY, pick_letter(6),
                     1'($urandom_range(0, 1)));
      end
      pause_until_drained();
   endtask

   // Random dictionary words, query runs and raw noise
   task automatic test_random_stream();
      int unsigned stop_at;
      int unsigned span;
      int unsigned pick;
      int unsigned len;
      int unsigned i;
      stop_at = letters_sent + RANDOM_ITEMS;
      while (letters_sent < stop_at) begin
         span = ($urandom_range(0, 3) == 0) ? ALPHABET : $urandom_range(4, 10);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // well-formed word, now and then split by a query
            if ($urandom_range(0, 32) == 0) begin
               len = 1;
            end else if ($urandom_range(0, 9) == 0) begin
               len = $urandom_range(10, 20);
            end else begin
               len = $urandom_range(3, 8);
            end
            for (i = 0; i < len; i++) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_letter(REQ_QUERY, pick_letter(span), 1'($urandom_range(0, 1)));
               end
               send_letter(REQ_LOAD, pick_letter(span), i == len - 1);
            end
         end else if (pick < 90) begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
               send_letter(REQ_QUERY, pick_letter(span), 1'($urandom_range(0, 1)));
            end
         end else begin
            // raw noise over the full field ranges
            send_letter(1'($urandom_range(0, 1)), LETTER_W'($urandom_range(0, LETTER_MAX)),
                        1'($urandom_range(0, 1)));
         end
      end
      pause_until_drained();
   endtask

   // Receiver: own stall pattern, switched now and then, plus a requested long hold-off
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_pending) begin
            holdoff_pending = 1'b0;
            holdoff_left    = HOLDOFF_LEN;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (rdy_mode_left == 0) begin
               rdy_mode      = rdy_mode_type'($urandom_range(0, 3));
               rdy_mode_left = $urandom_range(20, 300);
            end
            rdy_mode_left--;
            rdy_phase = (rdy_phase == 6) ? 0 : rdy_phase + 1;
            case (rdy_mode)
               RDY_ALWAYS:   rsp_if.ready <= 1'b1;
               RDY_COIN:     rsp_if.ready <= 1'($urandom_range(0, 1));
               RDY_PERIODIC: rsp_if.ready <= (rdy_phase < 4);
               default:      rsp_if.ready <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   // Compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      match_outcome_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("response with nothing pending");
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_if.matched !== want.matched) begin
               report_mismatch($sformatf("matched %0b, want %0b", rsp_if.matched, want.matched));
            end
            if (rsp_if.status !== want.status) begin
               report_mismatch($sformatf("status %0d, want %0d", rsp_if.status, want.status));
            end
         end
         rsp_count++;
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_stream_suffix_dictionary_matcher_core NOT OK");
      $finish;
   end

   initial begin
      req_if.valid        <= 1'b0;
      req_if.req_type     <= REQ_LOAD;
      req_if.letter       <= '0;
      req_if.last_of_word <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_words();
      test_word_length_limits();
      test_response_holdoff();
      test_random_stream();
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("tb_stream_suffix_dictionary_matcher_core OK");
      end else begin
         $display("tb_stream_suffix_dictionary_matcher_core NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
sv/sdm_pkg.sv
sv/sdm_req_if.sv
sv/sdm_rsp_if.sv
sv/sdm_node_table.sv
sv/stream_suffix_dictionary_matcher_core.sv
tb/tb_stream_suffix_dictionary_matcher_core.sv
